// ----- rtl/wfftdb_pkg.sv -----
// ----------------------------------------------------------------------------
// wfftdb_pkg
// Shared types, constants and elaboration-time tables for the windowed FFT
// spectrum block: sequencer states, Hann weights, twiddles, saturation.
// ----------------------------------------------------------------------------
package wfftdb_pkg;

	localparam int DATA_W    = 24;   // store word, signed Q9.15
	localparam int POW_W     = 48;   // re^2 + im^2
	localparam int WIN_TAB_N = 256;  // all sizes 2..128 packed, base n-2
	localparam int TW_TAB_N  = 64;   // phases m*512

	localparam logic signed [18:0] DB_PER_LOG2 = 19'sd197283;  // 10*log10(2), Q16
	localparam logic signed [15:0] DB_MIN      = -16'sd20480;
	localparam logic signed [15:0] DB_MAX      = 16'sd12800;

	localparam logic [63:0] C1  = 64'd1686629713;
	localparam logic [63:0] C3  = 64'd693598668;
	localparam logic [63:0] C5  = 64'd85569306;
	localparam logic [63:0] C7  = 64'd5026995;
	localparam logic [63:0] C9  = 64'd172272;
	localparam logic [63:0] C11 = 64'd3864;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_WIN,
		ST_COPY,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WA,
		ST_BF_WB,
		ST_LV_RD,
		ST_LV_SQ,
		ST_LV_SUM,
		ST_LV_NORM,
		ST_LV_LOG,
		ST_LV_SCL,
		ST_LV_OUT
	} state_t;

	typedef logic [15:0]        win_tab_t [WIN_TAB_N];
	typedef logic signed [16:0] tw_tab_t  [TW_TAB_N];

	// sin(2*pi*ph/65536) in Q1.15, odd polynomial with truncating Horner steps
	function automatic logic signed [16:0] sin_turn(input logic [15:0] ph);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] s;
		x = {48'd0, ph[13:0], 2'b00};
		if (ph[14]) begin
			x = 64'd65536 - x;
		end
		x  = x << 14;
		x2 = (x * x) >> 30;
		r  = C11;
		r  = C9 - ((r * x2) >> 30);
		r  = C7 - ((r * x2) >> 30);
		r  = C5 - ((r * x2) >> 30);
		r  = C3 - ((r * x2) >> 30);
		r  = C1 - ((r * x2) >> 30);
		s  = (((r * x) >> 30) + 64'd16384) >> 15;
		if (s > 64'd32768) begin
			s = 64'd32768;
		end
		return ph[15] ? -$signed(17'(s)) : $signed(17'(s));
	endfunction

	// Hann weights for every size; phase round(i*32768/(n-1)) tracked as
	// quotient and remainder so no division is needed
	function automatic win_tab_t build_win();
		win_tab_t          t;
		int                lg;
		int                i;
		int                d;
		int                q;
		int                r;
		int                sq;
		int                sr;
		logic signed [16:0] s;
		longint            p;
		for (i = 0; i < WIN_TAB_N; i++) begin
			t[i] = '0;
		end
		for (lg = 1; lg <= 7; lg++) begin
			d = (1 << lg) - 1;
			case (lg)
				1: begin sq = 32768; sr = 0; end
				2: begin sq = 10922; sr = 2; end
				3: begin sq = 4681;  sr = 1; end
				4: begin sq = 2184;  sr = 8; end
				5: begin sq = 1057;  sr = 1; end
				6: begin sq = 520;   sr = 8; end
				default: begin sq = 258; sr = 2; end
			endcase
			q = 0;
			r = d >> 1;
			for (i = 0; i <= d; i++) begin
				s = sin_turn(q[15:0]);
				p = (longint'(s) * longint'(s) + 64'sd16384) >>> 15;
				t[d - 1 + i] = p[15:0];
				r = r + sr;
				q = q + sq;
				if (r >= d) begin
					r = r - d;
					q = q + 1;
				end
			end
		end
		return t;
	endfunction

	// cos (sel=1) or sin (sel=0) of phase m*512
	function automatic tw_tab_t build_tw(input logic cos_sel);
		tw_tab_t t;
		int      m;
		for (m = 0; m < TW_TAB_N; m++) begin
			t[m] = sin_turn(16'(m * 512 + (cos_sel ? 16384 : 0)));
		end
		return t;
	endfunction

	localparam win_tab_t WIN_TAB = build_win();
	localparam tw_tab_t  TW_COS  = build_tw(1'b1);
	localparam tw_tab_t  TW_SIN  = build_tw(1'b0);

	function automatic logic signed [DATA_W-1:0] sat24(input logic signed [47:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 48'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -48'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/windowed_fft_spectrum_db.sv -----
// ----------------------------------------------------------------------------
// windowed_fft_spectrum_db
// Hann-windowed radix-2 DIT FFT over one frame, emitting N/2 bin levels in dB.
// ----------------------------------------------------------------------------
// Samples stream in one per beat; the first N = 2^log2_points of a frame are
// kept in the real store and the rest are dropped. The beat that carries
// frame_end starts the transform: a window pass (weight times sample, written
// bit-reversed into the imag store), a copy pass (imag back to real, imag
// cleared), then lg stages of N/2 butterflies, each a read of both legs, a
// multiply step, an add step and two writes through the single store write
// port. Each bin then goes through the level unit: squares, sum, a 6-step
// normalize, 16 squaring steps for the log2 fraction and a scale multiply; a
// bin of zero power skips from the sum straight to the output. A frame_end
// arriving with fewer than N samples returns one status beat and no bins.
// Input is taken only while loading; the output register lets the last bin
// wait while the next frame loads, and only a frame_end beat is held off
// until that register is free. log2_points may change mid-frame and takes
// effect at once; 0 acts as 1 and values above the maximum clamp.
// ----------------------------------------------------------------------------
module windowed_fft_spectrum_db #(
	parameter int MAX_LOG2_POINTS = 7,
	parameter int SAMPLE_WIDTH    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [5:0]                     bin_index,
	output logic signed [15:0]             level_db,
	output logic                           status,
	output logic                           last_bin
);
	import wfftdb_pkg::*;

	localparam int AW    = MAX_LOG2_POINTS;
	localparam int CW    = AW + 1;
	localparam int DEPTH = 1 << AW;
	localparam int PW    = SAMPLE_WIDTH + 17;
	localparam logic signed [PW-1:0] WIN_RND = PW'(1) << (SAMPLE_WIDTH - 2);

	function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v, input logic [2:0] lg);
		logic [AW-1:0] f;
		for (int b = 0; b < AW; b++) begin
			f[b] = v[AW-1-b];
		end
		return f >> (3'(AW) - lg);
	endfunction

	// sequencer and control
	state_t        state_q, state_d;
	logic [2:0]    cfg_q, lg_q, lg_eff;
	logic [CW-1:0] cnt_q, cnt_inc, n_ld, n_cw, idx_q;
	logic [AW-1:0] nh_m1, bfly_q, k_q, lmask, jj, addr_a, addr_b;
	logic [2:0]    stg_q;
	logic [3:0]    step_q;
	logic          accept, cnt_store, full, issue, out_free;
	logic          bf_last, stg_last, k_last;

	// stores: one write port, two registered read ports
	logic signed [DATA_W-1:0] re_mem [DEPTH];
	logic signed [DATA_W-1:0] im_mem [DEPTH];
	logic                     we_re, we_im;
	logic [AW-1:0]            waddr, raddr0, raddr1;
	logic signed [DATA_W-1:0] wdata_re, wdata_im;
	logic signed [DATA_W-1:0] re_rd0, re_rd1, im_rd0, im_rd1;

	// window pass
	logic                 v_s1, v_s2;
	logic [AW-1:0]        i_s1, i_s2;
	logic [15:0]          w_s1;
	logic signed [PW-1:0] prod_s2, win_sum;
	logic [8:0]           n9;
	logic [7:0]           wtab_idx;

	// butterfly
	logic [6:0]        tw_sh;
	logic [5:0]        tw_idx;
	logic signed [16:0] c_q, s_q;
	logic signed [40:0] p_cr_q, p_si_q, p_ci_q, p_sr_q;
	logic signed [DATA_W-1:0] ur_q, ui_q;
	logic signed [41:0] bsum_r, bsum_i;
	logic signed [26:0] tr_q, ti_q;

	// level unit
	logic signed [47:0] sqr_full, sqi_full;
	logic [46:0]        sqr_q, sqi_q;
	logic [POW_W-1:0]   pw_q, pw_sum, pw_nx, top_mask;
	logic [5:0]         e_q, sh;
	logic               zero_q, top_zero;
	logic [30:0]        m_q;
	logic [61:0]        mm;
	logic [31:0]        mm_hi;
	logic [15:0]        frac_q;
	logic signed [22:0] level_l;
	logic signed [41:0] scl_q, db_rnd;
	logic signed [15:0] db_clamp;

	// output register
	logic              out_valid_q, out_ld, out_st, out_last;
	logic [5:0]        out_bin, bin_q;
	logic signed [15:0] out_db, db_q;
	logic              status_q, last_q;

	assign lg_eff    = (cfg_q == 3'd0) ? 3'd1 :
		(cfg_q > 3'(MAX_LOG2_POINTS)) ? 3'(MAX_LOG2_POINTS) : cfg_q;
	assign n_ld      = CW'(1) << lg_eff;
	assign n_cw      = CW'(1) << lg_q;
	assign nh_m1     = AW'(n_cw >> 1) - AW'(1);
	assign out_free  = !out_valid_q || out_ready;
	// plain samples load while a result waits; frame_end needs the output free
	assign in_ready  = (state_q == ST_LOAD) && (out_free || !frame_end);
	assign accept    = in_valid && in_ready;
	assign cnt_store = cnt_q < n_ld;
	assign cnt_inc   = cnt_store ? cnt_q + CW'(1) : cnt_q;
	assign full      = !(cnt_inc < n_ld);
	assign issue     = idx_q < n_cw;

	assign n9       = 9'(n_cw);
	assign wtab_idx = 8'(n9 - 9'd2 + 9'(idx_q));
	assign win_sum  = prod_s2 + WIN_RND;

	// butterfly legs: a = group*2*half + j, b = a + half
	assign lmask    = (AW'(1) << stg_q) - AW'(1);
	assign jj       = bfly_q & lmask;
	assign addr_a   = ((bfly_q & ~lmask) << 1) | jj;
	assign addr_b   = addr_a | (AW'(1) << stg_q);
	assign tw_sh    = 7'(jj) << (3'd6 - stg_q);
	assign tw_idx   = tw_sh[5:0];
	assign bf_last  = bfly_q == nh_m1;
	assign stg_last = stg_q == (lg_q - 3'd1);
	assign k_last   = k_q == nh_m1;

	assign bsum_r = 42'(p_cr_q) + 42'(p_si_q) + 42'sd16384;
	assign bsum_i = 42'(p_ci_q) - 42'(p_sr_q) + 42'sd16384;

	assign sqr_full = re_rd0 * re_rd0;
	assign sqi_full = im_rd0 * im_rd0;
	assign pw_sum   = {1'b0, sqr_q} + {1'b0, sqi_q};
	assign sh       = 6'd32 >> step_q[2:0];
	assign top_mask = ~({POW_W{1'b1}} >> sh);
	assign top_zero = (pw_q & top_mask) == '0;
	assign pw_nx    = top_zero ? (pw_q << sh) : pw_q;
	assign mm       = m_q * m_q;
	assign mm_hi    = mm[61:30];
	assign level_l  = {7'(e_q) - 7'd30, frac_q};
	assign db_rnd   = (scl_q + 42'sd8388608) >>> 24;

	always_comb begin
		if (db_rnd < -42'sd20480) begin
			db_clamp = DB_MIN;
		end else if (db_rnd > 42'sd12800) begin
			db_clamp = DB_MAX;
		end else begin
			db_clamp = db_rnd[15:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && frame_end && full) state_d = ST_WIN;
			end
			ST_WIN: begin
				if (!issue && !v_s1 && !v_s2) state_d = ST_COPY;
			end
			ST_COPY: begin
				if (!issue && !v_s1) state_d = ST_BF_RD;
			end
			ST_BF_RD:  state_d = ST_BF_MUL;
			ST_BF_MUL: state_d = ST_BF_ADD;
			ST_BF_ADD: state_d = ST_BF_WA;
			ST_BF_WA:  state_d = ST_BF_WB;
			ST_BF_WB: begin
				state_d = (bf_last && stg_last) ? ST_LV_RD : ST_BF_RD;
			end
			ST_LV_RD:  state_d = ST_LV_SQ;
			ST_LV_SQ:  state_d = ST_LV_SUM;
			ST_LV_SUM: begin
				state_d = (pw_sum == '0) ? ST_LV_OUT : ST_LV_NORM;
			end
			ST_LV_NORM: begin
				if (step_q == 4'd5) state_d = ST_LV_LOG;
			end
			ST_LV_LOG: begin
				if (step_q == 4'd15) state_d = ST_LV_SCL;
			end
			ST_LV_SCL: state_d = ST_LV_OUT;
			ST_LV_OUT: begin
				if (out_free) state_d = k_last ? ST_LOAD : ST_LV_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// store ports and output loads
	always_comb begin
		we_re    = 1'b0;
		we_im    = 1'b0;
		waddr    = '0;
		wdata_re = '0;
		wdata_im = '0;
		raddr0   = '0;
		raddr1   = '0;
		out_ld   = 1'b0;
		out_bin  = '0;
		out_db   = '0;
		out_st   = 1'b0;
		out_last = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (accept && cnt_store) begin
					we_re    = 1'b1;
					waddr    = cnt_q[AW-1:0];
					wdata_re = DATA_W'(sample);
				end
				if (accept && frame_end && !full) begin
					out_ld   = 1'b1;
					out_st   = 1'b1;
					out_last = 1'b1;
				end
			end
			ST_WIN: begin
				raddr0 = idx_q[AW-1:0];
				if (v_s2) begin
					we_im    = 1'b1;
					waddr    = bit_rev(i_s2, lg_q);
					wdata_im = DATA_W'(win_sum >>> (SAMPLE_WIDTH - 1));
				end
			end
			ST_COPY: begin
				raddr0 = idx_q[AW-1:0];
				if (v_s1) begin
					we_re    = 1'b1;
					we_im    = 1'b1;
					waddr    = i_s1;
					wdata_re = im_rd0;
				end
			end
			ST_BF_RD: begin
				raddr0 = addr_a;
				raddr1 = addr_b;
			end
			ST_BF_WA: begin
				we_re    = 1'b1;
				we_im    = 1'b1;
				waddr    = addr_a;
				wdata_re = sat24(48'(ur_q) + 48'(tr_q));
				wdata_im = sat24(48'(ui_q) + 48'(ti_q));
			end
			ST_BF_WB: begin
				we_re    = 1'b1;
				we_im    = 1'b1;
				waddr    = addr_b;
				wdata_re = sat24(48'(ur_q) - 48'(tr_q));
				wdata_im = sat24(48'(ui_q) - 48'(ti_q));
			end
			ST_LV_RD: begin
				raddr0 = k_q;
			end
			ST_LV_OUT: begin
				if (out_free) begin
					out_ld   = 1'b1;
					out_bin  = 6'(k_q);
					out_db   = zero_q ? DB_MIN : db_clamp;
					out_last = k_last;
				end
			end
			default: begin
			end
		endcase
	end

	// stores
	always_ff @(posedge clk) begin
		if (we_re) re_mem[waddr] <= wdata_re;
		if (we_im) im_mem[waddr] <= wdata_im;
		re_rd0 <= re_mem[raddr0];
		re_rd1 <= re_mem[raddr1];
		im_rd0 <= im_mem[raddr0];
		im_rd1 <= im_mem[raddr1];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cfg_q       <= 3'd7;
			lg_q        <= 3'd1;
			cnt_q       <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			stg_q       <= '0;
			bfly_q      <= '0;
			k_q         <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q <= cfg_wdata;
			v_s1 <= issue && (state_q == ST_WIN || state_q == ST_COPY);
			v_s2 <= v_s1 && (state_q == ST_WIN);
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= frame_end ? '0 : cnt_inc;
						if (frame_end) begin
							lg_q  <= lg_eff;
							idx_q <= '0;
						end
					end
				end
				ST_WIN, ST_COPY: begin
					if (state_d != state_q) begin
						idx_q <= '0;
					end else if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					stg_q  <= '0;
					bfly_q <= '0;
				end
				ST_BF_WB: begin
					if (bf_last) begin
						bfly_q <= '0;
						stg_q  <= stg_q + 3'd1;
					end else begin
						bfly_q <= bfly_q + AW'(1);
					end
					k_q <= '0;
				end
				ST_LV_SUM: step_q <= '0;
				ST_LV_NORM: step_q <= (step_q == 4'd5) ? 4'd0 : step_q + 4'd1;
				ST_LV_LOG: step_q <= step_q + 4'd1;
				ST_LV_OUT: begin
					if (out_free && !k_last) k_q <= k_q + AW'(1);
				end
				default: begin
				end
			endcase
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		i_s1    <= idx_q[AW-1:0];
		w_s1    <= WIN_TAB[wtab_idx];
		i_s2    <= i_s1;
		prod_s2 <= $signed(re_rd0[SAMPLE_WIDTH-1:0]) * $signed({1'b0, w_s1});
		case (state_q)
			ST_BF_RD: begin
				c_q <= TW_COS[tw_idx];
				s_q <= TW_SIN[tw_idx];
			end
			ST_BF_MUL: begin
				p_cr_q <= c_q * re_rd1;
				p_si_q <= s_q * im_rd1;
				p_ci_q <= c_q * im_rd1;
				p_sr_q <= s_q * re_rd1;
				ur_q   <= re_rd0;
				ui_q   <= im_rd0;
			end
			ST_BF_ADD: begin
				tr_q <= 27'(bsum_r >>> 15);
				ti_q <= 27'(bsum_i >>> 15);
			end
			ST_LV_SQ: begin
				sqr_q <= sqr_full[46:0];
				sqi_q <= sqi_full[46:0];
			end
			ST_LV_SUM: begin
				pw_q   <= pw_sum;
				zero_q <= pw_sum == '0;
				e_q    <= 6'd47;
			end
			ST_LV_NORM: begin
				pw_q   <= pw_nx;
				m_q    <= pw_nx[47:17];
				frac_q <= '0;
				if (top_zero) e_q <= e_q - sh;
			end
			ST_LV_LOG: begin
				m_q    <= mm_hi[31] ? mm_hi[31:1] : mm_hi[30:0];
				frac_q <= {frac_q[14:0], mm_hi[31]};
			end
			ST_LV_SCL: begin
				scl_q <= level_l * DB_PER_LOG2;
			end
			default: begin
			end
		endcase
		if (out_ld) begin
			bin_q    <= out_bin;
			db_q     <= out_db;
			status_q <= out_st;
			last_q   <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = bin_q;
	assign level_db  = db_q;
	assign status    = status_q;
	assign last_bin  = last_q;

endmodule
